// File: hw/rtl/swlrl_pkg.sv
// Shared constants and types for the sliding-window-log rate limiter.
package swlrl_pkg;

  // Default sizes.
  localparam int TENANTS_DEF = 128;
  localparam int SLOTS_DEF   = 16;

  // Field and register widths.
  localparam int TENANT_W    = 7;
  localparam int STAMP_W     = 40;
  localparam int WINDOW_W    = 32;
  localparam int LIMIT_W     = 5;
  localparam int COUNT_OUT_W = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  // Register reset values.
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd10000;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 5'd10;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 1'b1;

  // Engine sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_EVICT,
    ST_DECIDE
  } state_e;

  // One result item.
  typedef struct packed {
    logic                   allowed;
    logic [COUNT_OUT_W-1:0] count;
  } result_t;

endpackage

// File: hw/rtl/sliding_window_log_rate_limiter.sv
// Top level of the per-tenant sliding-window-log rate limiter.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   tenant_i, timestamp_i
//   out      output     out_valid_o / out_stall_i allowed_o, window_count_o
//   cfg      input      cfg_we_i                  cfg_index_i, cfg_data_i
//
// One item at a time: an empty log goes from load straight to the decision, else
// the engine first pops the expired stamps, oldest first, and then decides; the
// pop loop reads the timestamp memory once per cycle.
// After reset the tenant state memory is cleared, with in_stall_o high.
// A result waits in the output register while out_stall_i is high; the next
// item is still taken and runs up to its decision.
module sliding_window_log_rate_limiter #(
  parameter int TENANTS = swlrl_pkg::TENANTS_DEF,
  parameter int SLOTS   = swlrl_pkg::SLOTS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [swlrl_pkg::TENANT_W-1:0]      tenant_i,
  input  logic [swlrl_pkg::STAMP_W-1:0]       timestamp_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                allowed_o,
  output logic [swlrl_pkg::COUNT_OUT_W-1:0]   window_count_o,
  input  logic                                cfg_we_i,
  input  logic [swlrl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [swlrl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int TW   = (TENANTS > 1) ? $clog2(TENANTS) : 1;
  localparam int SW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int MW   = SW + CW;
  localparam int AW   = (TENANTS * SLOTS > 1) ? $clog2(TENANTS * SLOTS) : 1;
  localparam int NRAW = 2 ** swlrl_pkg::TENANT_W;

  logic [swlrl_pkg::WINDOW_W-1:0] window_q;
  logic [swlrl_pkg::LIMIT_W-1:0]  limit_q;

  logic [TW-1:0]                 fold_lut [NRAW];
  logic [TW-1:0]                 tenant_idx;
  swlrl_pkg::result_t            res;

  logic [TW-1:0]                 meta_raddr;
  logic [MW-1:0]                 meta_rdata;
  logic                          meta_we;
  logic [TW-1:0]                 meta_waddr;
  logic [MW-1:0]                 meta_wdata;
  logic [AW-1:0]                 stamp_raddr;
  logic [swlrl_pkg::STAMP_W-1:0] stamp_rdata;
  logic                          stamp_we;
  logic [AW-1:0]                 stamp_waddr;
  logic [swlrl_pkg::STAMP_W-1:0] stamp_wdata;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= swlrl_pkg::WINDOW_RESET;
      limit_q  <= swlrl_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        swlrl_pkg::CFG_WINDOW: window_q <= cfg_data_i;
        swlrl_pkg::CFG_LIMIT:  limit_q  <= cfg_data_i[swlrl_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Fold the tenant number onto the tenant range.
  for (genvar i = 0; i < NRAW; i++) begin : g_fold
    assign fold_lut[i] = TW'(i % TENANTS);
  end
  assign tenant_idx = fold_lut[tenant_i];

  swlrl_engine #(
    .TENANTS (TENANTS),
    .SLOTS   (SLOTS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .tenant_idx_i  (tenant_idx),
    .timestamp_i   (timestamp_i),
    .window_i      (window_q),
    .limit_i       (limit_q),
    .res_valid_o   (out_valid_o),
    .res_stall_i   (out_stall_i),
    .res_o         (res),
    .meta_raddr_o  (meta_raddr),
    .meta_rdata_i  (meta_rdata),
    .meta_we_o     (meta_we),
    .meta_waddr_o  (meta_waddr),
    .meta_wdata_o  (meta_wdata),
    .stamp_raddr_o (stamp_raddr),
    .stamp_rdata_i (stamp_rdata),
    .stamp_we_o    (stamp_we),
    .stamp_waddr_o (stamp_waddr),
    .stamp_wdata_o (stamp_wdata)
  );

  // Per-tenant oldest slot and entry count.
  swlrl_ram #(
    .WIDTH (MW),
    .DEPTH (TENANTS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  // Timestamp rings, SLOTS entries per tenant.
  swlrl_ram #(
    .WIDTH (swlrl_pkg::STAMP_W),
    .DEPTH (TENANTS * SLOTS)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (stamp_waddr),
    .wdata_i (stamp_wdata),
    .raddr_i (stamp_raddr),
    .rdata_o (stamp_rdata)
  );

  assign allowed_o      = res.allowed;
  assign window_count_o = res.count;

  // Only one item in flight: an accepted item closes the input.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while another is in flight");

  // An allowed item always leaves at least one logged stamp.
  a_allow_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && allowed_o && (SLOTS < 32) |-> window_count_o != '0)
    else $error("allowed item reports empty log");

  // The reported count never exceeds the ring size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(window_count_o) <= SLOTS)
    else $error("window count exceeds ring size");

endmodule

// File: hw/rtl/swlrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swlrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/swlrl_engine.sv
// Request sequencer: loads tenant state, pops expired stamps, logs and writes back.
module swlrl_engine #(
  parameter int TENANTS = swlrl_pkg::TENANTS_DEF,
  parameter int SLOTS   = swlrl_pkg::SLOTS_DEF,
  localparam int TW     = (TENANTS > 1) ? $clog2(TENANTS) : 1,
  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW     = $clog2(SLOTS + 1),
  localparam int MW     = SW + CW,
  localparam int AW     = (TENANTS * SLOTS > 1) ? $clog2(TENANTS * SLOTS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request side
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [TW-1:0]                     tenant_idx_i,
  input  logic [swlrl_pkg::STAMP_W-1:0]     timestamp_i,
  // configuration
  input  logic [swlrl_pkg::WINDOW_W-1:0]    window_i,
  input  logic [swlrl_pkg::LIMIT_W-1:0]     limit_i,
  // result side
  output logic                              res_valid_o,
  input  logic                              res_stall_i,
  output swlrl_pkg::result_t                res_o,
  // per-tenant state memory
  output logic [TW-1:0]                     meta_raddr_o,
  input  logic [MW-1:0]                     meta_rdata_i,
  output logic                              meta_we_o,
  output logic [TW-1:0]                     meta_waddr_o,
  output logic [MW-1:0]                     meta_wdata_o,
  // timestamp log memory
  output logic [AW-1:0]                     stamp_raddr_o,
  input  logic [swlrl_pkg::STAMP_W-1:0]     stamp_rdata_i,
  output logic                              stamp_we_o,
  output logic [AW-1:0]                     stamp_waddr_o,
  output logic [swlrl_pkg::STAMP_W-1:0]     stamp_wdata_o
);

  localparam int CMPW = (CW > swlrl_pkg::LIMIT_W) ? CW : swlrl_pkg::LIMIT_W;

  swlrl_pkg::state_e state_q, state_d;

  logic [TW-1:0]                 t_q;
  logic [swlrl_pkg::STAMP_W-1:0] now_q;
  logic [SW-1:0]                 head_q, head_d;
  logic [CW-1:0]                 count_q, count_d;
  logic [TW-1:0]                 clr_q;
  logic                          res_valid_q, res_valid_d;
  swlrl_pkg::result_t            res_q, res_d;

  logic                          accept;
  logic                          go;
  logic [AW-1:0]                 base;
  logic [SW-1:0]                 head_inc;
  logic [SW-1:0]                 meta_head;
  logic [CW-1:0]                 meta_count;
  logic                          expire;
  logic [swlrl_pkg::STAMP_W-1:0] age;
  logic [CMPW-1:0]               limit_x;
  logic [CMPW-1:0]               slots_x;
  logic [CMPW-1:0]               limit_eff;
  logic                          allow;
  logic [SW:0]                   tail_sum;
  logic [SW-1:0]                 tail;
  logic [CW-1:0]                 count_new;

  assign accept = in_valid_i && !in_stall_o;
  assign go     = !res_valid_q || !res_stall_i;

  // Tenant base address and ring arithmetic.
  assign base       = AW'(t_q) * AW'(SLOTS);
  assign head_inc   = (head_q == SW'(SLOTS - 1)) ? '0 : head_q + SW'(1);
  assign meta_head  = meta_rdata_i[MW-1:CW];
  assign meta_count = meta_rdata_i[CW-1:0];

  // Oldest entry expires when it is not in the future and at least a window old.
  assign age    = now_q - stamp_rdata_i;
  assign expire = (now_q >= stamp_rdata_i) &&
                  (age >= {{(swlrl_pkg::STAMP_W - swlrl_pkg::WINDOW_W){1'b0}}, window_i});

  // Clamp the limit to the ring size and decide.
  assign limit_x   = CMPW'(limit_i);
  assign slots_x   = CMPW'(SLOTS);
  assign limit_eff = (limit_x > slots_x) ? slots_x : limit_x;
  assign allow     = CMPW'(count_q) < limit_eff;
  assign tail_sum  = (SW + 1)'(head_q) + (SW + 1)'(count_q);
  assign tail      = (tail_sum >= (SW + 1)'(SLOTS)) ? SW'(tail_sum - (SW + 1)'(SLOTS))
                                                     : SW'(tail_sum);
  assign count_new = allow ? count_q + CW'(1) : count_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      swlrl_pkg::ST_CLEAR: begin
        if (clr_q == TW'(TENANTS - 1)) state_d = swlrl_pkg::ST_IDLE;
      end
      swlrl_pkg::ST_IDLE: begin
        if (accept) state_d = swlrl_pkg::ST_LOAD;
      end
      swlrl_pkg::ST_LOAD: begin
        state_d = (meta_count == '0) ? swlrl_pkg::ST_DECIDE : swlrl_pkg::ST_EVICT;
      end
      swlrl_pkg::ST_EVICT: begin
        if (!expire || count_q == CW'(1)) state_d = swlrl_pkg::ST_DECIDE;
      end
      swlrl_pkg::ST_DECIDE: begin
        if (go) state_d = swlrl_pkg::ST_IDLE;
      end
      default: state_d = swlrl_pkg::ST_CLEAR;
    endcase
  end

  // Datapath controls and memory ports.
  always_comb begin
    head_d        = head_q;
    count_d       = count_q;
    res_valid_d   = res_valid_q && res_stall_i;
    res_d         = res_q;
    meta_raddr_o  = tenant_idx_i;
    meta_we_o     = 1'b0;
    meta_waddr_o  = t_q;
    meta_wdata_o  = {head_q, count_new};
    stamp_raddr_o = base + AW'(head_q);
    stamp_we_o    = 1'b0;
    stamp_waddr_o = base + AW'(tail);
    stamp_wdata_o = now_q;
    case (state_q)
      swlrl_pkg::ST_CLEAR: begin
        meta_we_o    = 1'b1;
        meta_waddr_o = clr_q;
        meta_wdata_o = '0;
      end
      swlrl_pkg::ST_LOAD: begin
        head_d        = meta_head;
        count_d       = meta_count;
        stamp_raddr_o = base + AW'(meta_head);
      end
      swlrl_pkg::ST_EVICT: begin
        // pop one expired stamp and fetch the next oldest
        if (expire) begin
          head_d        = head_inc;
          count_d       = count_q - CW'(1);
          stamp_raddr_o = base + AW'(head_inc);
        end
      end
      swlrl_pkg::ST_DECIDE: begin
        if (go) begin
          stamp_we_o    = allow;
          meta_we_o     = 1'b1;
          res_valid_d   = 1'b1;
          res_d.allowed = allow;
          res_d.count   = swlrl_pkg::COUNT_OUT_W'(count_new);
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swlrl_pkg::ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (state_q == swlrl_pkg::ST_CLEAR) clr_q <= clr_q + TW'(1);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q   <= tenant_idx_i;
      now_q <= timestamp_i;
    end
    head_q  <= head_d;
    count_q <= count_d;
    res_q   <= res_d;
  end

  assign in_stall_o  = (state_q != swlrl_pkg::ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
